[rtl/core/sched_pkg.sv]
package sched_pkg;

    // Table geometry
    localparam int TASK_SLOTS = 16;
    localparam int SLOT_IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int SCAN_W     = SLOT_IDX_W + 1;

    // Field widths
    localparam int ID_W   = 8;
    localparam int WORK_W = 16;
    localparam int TIME_W = 32;
    localparam int STAT_W = 16;

    // Stream packing
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 3;

    // Input item kinds carried on s_tuser
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Scheduling policy register codes
    localparam logic MODE_SRTF = 1'b0;
    localparam logic MODE_EDF  = 1'b1;

    // One task slot as held in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [WORK_W-1:0] remaining;
        logic [WORK_W-1:0] burst;
        logic [WORK_W-1:0] deadline;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] start;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // One result item
    typedef struct packed {
        logic              accepted;
        logic              ran;
        logic [ID_W-1:0]   run_id;
        logic              finished;
        logic [STAT_W-1:0] response;
        logic [STAT_W-1:0] waiting;
        logic [STAT_W-1:0] turnaround;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_STAT,
        ST_EMIT
    } sched_state_t;

    // Clamp a time difference to the statistic width
    function automatic logic [STAT_W-1:0] sat16(input logic [TIME_W-1:0] v);
        logic [STAT_W-1:0] r;
        r = (|v[TIME_W-1:STAT_W]) ? {STAT_W{1'b1}} : v[STAT_W-1:0];
        return r;
    endfunction

endpackage

[rtl/core/sched_ram.sv]
module sched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/preemptive_srtf_edf_scheduler_unit.sv]
// Channel   Direction  Handshake           Content
// s_        in         s_tvalid/s_tready   one arrival or one tick per transaction
// m_        out        m_tvalid/m_tready   one result per input transaction
// cfg_      in         cfg_valid/cfg_ready policy_mode register write
//
// An arrival passes from idle through emit into the result register; s_tready rises again as it is loaded.
// A tick passes through scan, pick, stat and emit before it reaches the result register:
// the slot memory read port walks every slot once, one entry per cycle, before the winner
// is updated.
// Reset clears time, slot occupancy and the policy; slot payload needs no clearing.
// A result waiting on m_tready lets one more transaction in, which then waits in emit with
// s_tready low until the output register frees.
module preemptive_srtf_edf_scheduler_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] task_id, [23:8] burst, [39:24] deadline
    input  logic [sched_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] op
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] run_id, [23:8] response, [39:24] waiting, [55:40] turnaround
    output logic [sched_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [0] accepted, [1] ran, [2] finished
    output logic [sched_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data
);

    import sched_pkg::*;

    sched_state_t            state_reg, state_next;
    logic                    policy_reg;
    logic [TIME_W-1:0]       time_reg, time_next;
    logic [TASK_SLOTS-1:0]   slot_valid_reg, slot_valid_next;
    logic [TASK_SLOTS-1:0]   slot_started_reg, slot_started_next;
    logic [SCAN_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                    best_found_reg, best_found_next;
    logic [SLOT_IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [WORK_W-1:0]       best_key_reg, best_key_next;
    slot_entry_t             best_entry_reg, best_entry_next;
    logic [TIME_W-1:0]       resp_raw_reg, resp_raw_next;
    logic [TIME_W-1:0]       turn_raw_reg, turn_raw_next;
    logic                    fin_reg, fin_next;
    result_t                 pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;

    // Slot memory ports
    logic                    ram_we;
    logic [SLOT_IDX_W-1:0]   ram_waddr;
    slot_entry_t             ram_wentry;
    logic [SLOT_IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;
    slot_entry_t             rd_entry;

    // Input fields
    logic [ID_W-1:0]         in_id;
    logic [WORK_W-1:0]       in_burst;
    logic [WORK_W-1:0]       in_deadline;
    logic                    in_accept;

    // Lowest free slot
    logic                    free_found;
    logic [SLOT_IDX_W-1:0]   free_idx;

    // Scan compare and winner update
    logic [SCAN_W-1:0]       cmp_cnt;
    logic [SLOT_IDX_W-1:0]   cmp_idx;
    logic [WORK_W-1:0]       cmp_key;
    logic [WORK_W-1:0]       rem_new;
    logic [TIME_W-1:0]       start_new;
    logic [TIME_W-1:0]       time_inc;
    logic [TIME_W-1:0]       wait_raw;

    assign in_id       = s_tdata[7:0];
    assign in_burst    = s_tdata[23:8];
    assign in_deadline = s_tdata[39:24];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.turnaround, out_reg.waiting, out_reg.response, out_reg.run_id};
    assign m_tuser  = {out_reg.finished, out_reg.ran, out_reg.accepted};

    // Writes happen only in idle and pick, reads only in scan, so no entry is
    // read and written in overlapping cycles
    sched_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TASK_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = slot_entry_t'(ram_rdata);

    // Find the lowest unoccupied slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_IDX_W'(i);
            end
        end
    end

    // Scan addressing: the entry read last cycle is compared now
    assign ram_raddr = (scan_cnt_reg < SCAN_W'(TASK_SLOTS)) ?
                       scan_cnt_reg[SLOT_IDX_W-1:0] : '0;
    assign cmp_cnt   = scan_cnt_reg - SCAN_W'(1);
    assign cmp_idx   = cmp_cnt[SLOT_IDX_W-1:0];
    assign cmp_key   = (policy_reg == MODE_EDF) ? rd_entry.deadline : rd_entry.remaining;

    // Winner update terms
    assign rem_new   = best_entry_reg.remaining - WORK_W'(1);
    assign start_new = slot_started_reg[best_idx_reg] ? best_entry_reg.start : time_reg;
    assign time_inc  = time_reg + TIME_W'(1);
    assign wait_raw  = (turn_raw_reg >= TIME_W'(best_entry_reg.burst)) ?
                       (turn_raw_reg - TIME_W'(best_entry_reg.burst)) : '0;

    // Next state and datapath
    always_comb begin
        state_next        = state_reg;
        time_next         = time_reg;
        slot_valid_next   = slot_valid_reg;
        slot_started_next = slot_started_reg;
        scan_cnt_next     = scan_cnt_reg;
        best_found_next   = best_found_reg;
        best_idx_next     = best_idx_reg;
        best_key_next     = best_key_reg;
        best_entry_next   = best_entry_reg;
        resp_raw_next     = resp_raw_reg;
        turn_raw_next     = turn_raw_reg;
        fin_next          = fin_reg;
        pend_next         = pend_reg;
        out_valid_next    = out_valid_reg;
        out_next          = out_reg;
        ram_we            = 1'b0;
        ram_waddr         = free_idx;
        ram_wentry        = '{id: in_id, remaining: in_burst, burst: in_burst,
                              deadline: in_deadline, arrival: time_reg, start: '0};

        // Drop the result once taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    pend_next = '0;
                    if (s_tuser == OP_TICK) begin
                        scan_cnt_next   = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end else begin
                        // Store the arrival in the lowest free slot
                        if (free_found && (in_burst != '0)) begin
                            ram_we                      = 1'b1;
                            slot_valid_next[free_idx]   = 1'b1;
                            slot_started_next[free_idx] = 1'b0;
                            pend_next.accepted          = 1'b1;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SCAN: begin
                // Keep the smallest key; ties stay with the lower slot
                if (scan_cnt_reg != '0) begin
                    if (slot_valid_reg[cmp_idx] &&
                        (!best_found_reg || (cmp_key < best_key_reg))) begin
                        best_found_next = 1'b1;
                        best_idx_next   = cmp_idx;
                        best_key_next   = cmp_key;
                        best_entry_next = rd_entry;
                    end
                end
                if (scan_cnt_reg == SCAN_W'(TASK_SLOTS)) begin
                    state_next = ST_PICK;
                end else begin
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                end
            end

            ST_PICK: begin
                time_next = time_inc;
                if (best_found_reg) begin
                    // Run the winner for one unit and write it back
                    ram_we                          = 1'b1;
                    ram_waddr                       = best_idx_reg;
                    ram_wentry                      = best_entry_reg;
                    ram_wentry.remaining            = rem_new;
                    ram_wentry.start                = start_new;
                    best_entry_next.remaining       = rem_new;
                    slot_started_next[best_idx_reg] = 1'b1;
                    fin_next                        = (rem_new == '0);
                    resp_raw_next                   = start_new - best_entry_reg.arrival;
                    turn_raw_next                   = time_inc - best_entry_reg.arrival;
                    if (rem_new == '0) begin
                        slot_valid_next[best_idx_reg]   = 1'b0;
                        slot_started_next[best_idx_reg] = 1'b0;
                    end
                end else begin
                    fin_next = 1'b0;
                end
                state_next = ST_STAT;
            end

            ST_STAT: begin
                // Build the tick result with clamped statistics
                pend_next = '0;
                if (best_found_reg) begin
                    pend_next.ran    = 1'b1;
                    pend_next.run_id = best_entry_reg.id;
                    if (fin_reg) begin
                        pend_next.finished   = 1'b1;
                        pend_next.response   = sat16(resp_raw_reg);
                        pend_next.waiting    = sat16(wait_raw);
                        pend_next.turnaround = sat16(turn_raw_reg);
                    end
                end
                state_next = ST_EMIT;
            end

            ST_EMIT: begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            policy_reg       <= MODE_SRTF;
            time_reg         <= '0;
            slot_valid_reg   <= '0;
            slot_started_reg <= '0;
            scan_cnt_reg     <= '0;
            best_found_reg   <= 1'b0;
            fin_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            time_reg         <= time_next;
            slot_valid_reg   <= slot_valid_next;
            slot_started_reg <= slot_started_next;
            scan_cnt_reg     <= scan_cnt_next;
            best_found_reg   <= best_found_next;
            fin_reg          <= fin_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                policy_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        best_idx_reg   <= best_idx_next;
        best_key_reg   <= best_key_next;
        best_entry_reg <= best_entry_next;
        resp_raw_reg   <= resp_raw_next;
        turn_raw_reg   <= turn_raw_next;
        pend_reg       <= pend_next;
        out_reg        <= out_next;
    end

    // A started task always occupies its slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_started_reg & ~slot_valid_reg) == '0)
        else $error("started flag set on a free slot");

    // The scan counter never runs past the last slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= SCAN_W'(TASK_SLOTS)))
        else $error("slot scan overran the table");

    // The chosen slot is occupied when it is run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK && best_found_reg) |-> slot_valid_reg[best_idx_reg])
        else $error("scheduler picked a free slot");

    // A tick that finishes its task frees the slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK && best_found_reg && rem_new == '0)
        |=> !slot_valid_reg[$past(best_idx_reg)])
        else $error("finished task still occupies its slot");

    // An arrival result never reports a run, and finishing implies running
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.accepted && out_reg.ran) &&
                          (!out_reg.finished || out_reg.ran))
        else $error("inconsistent result flags");

endmodule
